@@ hdl/lmb_pkg.sv @@
// ----------------------------------------------------------------------------
// lmb_pkg
// Types and constants shared by the level meter ballistics block.
// ----------------------------------------------------------------------------
package lmb_pkg;

  localparam logic [15:0] ATTACK_RESET  = 16'd53150;
  localparam logic [15:0] RELEASE_RESET = 16'd5242;
  localparam logic [15:0] DECAY_RESET   = 16'd2150;
  localparam logic [15:0] FLOOR_RESET   = 16'hC400;
  localparam logic [15:0] CEILING_RESET = 16'd3072;
  localparam logic [7:0]  HOLD_RESET    = 8'd30;

  localparam logic [15:0] PEAK_DB_RESET = 16'hC400;

  localparam logic signed [19:0] DB_SCALE = 20'sd394566;

  typedef enum logic [2:0] {
    REG_ATTACK  = 3'd0,
    REG_RELEASE = 3'd1,
    REG_DECAY   = 3'd2,
    REG_FLOOR   = 3'd3,
    REG_CEILING = 3'd4,
    REG_HOLD    = 3'd5
  } lmb_reg_e;

  typedef struct packed {
    logic [1:0]  channel_index;
    logic [19:0] new_level;
  } lmb_in_t;

  typedef struct packed {
    logic [1:0]  out_channel;
    logic [19:0] smoothed_level;
    logic [15:0] level_db_out;
    logic [15:0] peak_db_out;
  } lmb_out_t;

  typedef struct packed {
    logic [19:0] level;
    logic [19:0] peak;
    logic [15:0] peak_db;
    logic [7:0]  hold;
  } lmb_entry_t;

  typedef struct packed {
    logic        start;
    logic [19:0] x;
  } lmb_log_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] db;
  } lmb_log_rsp_t;

endpackage

@@ hdl/lmb_ram.sv @@
// ----------------------------------------------------------------------------
// lmb_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lmb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/lmb_log_db.sv @@
// ----------------------------------------------------------------------------
// lmb_log_db
// Converts a Q4.16 level to a clamped Q8.8 decibel value. The log2 fraction
// is built by one squaring round of the mantissa per cycle.
// ----------------------------------------------------------------------------
module lmb_log_db (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lmb_pkg::lmb_log_req_t req_i,
  input  logic [15:0]          floor_db_i,
  input  logic [15:0]          ceiling_db_i,
  output lmb_pkg::lmb_log_rsp_t rsp_o
);
  import lmb_pkg::*;

  typedef enum logic [1:0] {
    L_IDLE,
    L_SQUARE,
    L_MUL,
    L_FIN
  } log_state_e;

  log_state_e        state_q;
  logic [4:0]        exp_q;
  logic [31:0]       mant_q;
  logic [15:0]       frac_q;
  logic [3:0]        cnt_q;
  logic signed [40:0] prod_q;
  logic              done_q;
  logic [15:0]       db_q;

  logic [4:0]        lead;
  logic [31:0]       norm;
  logic [63:0]       sq;
  logic signed [20:0] log_val;
  logic signed [40:0] prod_d;
  logic signed [40:0] rnd;
  logic signed [15:0] raw_db;
  logic signed [15:0] clamp_db;

  always_comb begin
    lead = 5'd0;
    for (int i = 0; i < 20; i++) begin
      if (req_i.x[i]) begin
        lead = 5'(i);
      end
    end
    norm = {12'd0, req_i.x} << (5'd31 - lead);
  end

  assign sq = {32'd0, mant_q} * {32'd0, mant_q};

  assign log_val = $signed({5'(exp_q - 5'd16), frac_q});
  assign prod_d  = log_val * DB_SCALE;
  assign rnd     = prod_q + 41'sd8388608;
  assign raw_db  = $signed(rnd[39:24]);

  always_comb begin
    clamp_db = raw_db;
    if (clamp_db < $signed(floor_db_i)) begin
      clamp_db = $signed(floor_db_i);
    end
    if (clamp_db > $signed(ceiling_db_i)) begin
      clamp_db = $signed(ceiling_db_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
      exp_q   <= '0;
      mant_q  <= '0;
      frac_q  <= '0;
      cnt_q   <= '0;
      prod_q  <= '0;
      db_q    <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        L_IDLE: begin
          if (req_i.start) begin
            if (req_i.x == 20'd0) begin
              db_q   <= floor_db_i;
              done_q <= 1'b1;
            end else begin
              exp_q   <= lead;
              mant_q  <= norm;
              frac_q  <= '0;
              cnt_q   <= '0;
              state_q <= L_SQUARE;
            end
          end
        end
        L_SQUARE: begin
          if (sq[63]) begin
            mant_q <= sq[63:32];
            frac_q <= {frac_q[14:0], 1'b1};
          end else begin
            mant_q <= sq[62:31];
            frac_q <= {frac_q[14:0], 1'b0};
          end
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            state_q <= L_MUL;
          end
        end
        L_MUL: begin
          prod_q  <= prod_d;
          state_q <= L_FIN;
        end
        L_FIN: begin
          db_q    <= clamp_db;
          done_q  <= 1'b1;
          state_q <= L_IDLE;
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.db   = db_q;

endmodule

@@ hdl/level_meter_ballistics.sv @@
// ----------------------------------------------------------------------------
// level_meter_ballistics
// Per-channel meter ballistics: attack/release smoothing, dB conversion and
// peak hold with decay. Channel state lives in one RAM, read-modify-written.
// ----------------------------------------------------------------------------
// A transaction reads its entry, steps the level, converts it to dB, steps and
// converts the peak when it decays, writes the entry back and outputs the result;
// a channel beyond CHANNELS goes straight to the output. Input stalls until the
// result is loaded; nonzero conversions run 16 squaring rounds, one per cycle.
// Reset: registers take their reset values and all channel entries read as
// cleared at once through per-entry valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module level_meter_ballistics #(
  parameter int CHANNELS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lmb_pkg::lmb_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lmb_pkg::lmb_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import lmb_pkg::*;

  localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EW    = $bits(lmb_entry_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_STEP,
    S_LVL_START,
    S_LVL_WAIT,
    S_PK_STEP,
    S_PK_START,
    S_PK_WAIT,
    S_WRITE,
    S_OUT
  } state_e;

  logic [15:0] attack_q, release_q, decay_q, floor_q, ceiling_q;
  logic [7:0]  hold_ticks_q;

  state_e              state_q;
  logic [CHANNELS-1:0] valid_q;
  logic [CH_AW-1:0]    idx_q;
  logic [1:0]          ch_q;
  logic [19:0]         nl_q;
  logic [19:0]         lvl_q;
  logic [19:0]         peak_q;
  logic [15:0]         ldb_q;
  logic [15:0]         pdb_q;
  logic [7:0]          hold_q;
  logic                out_valid_q;
  lmb_out_t            out_q;

  logic             in_accept;
  logic [4:0]       ch_ext;
  logic             in_range;
  logic [EW-1:0]    rdata;
  lmb_entry_t       entry;
  lmb_entry_t       wentry;
  logic [19:0]      step_cur, step_tgt, step_res;
  logic [15:0]      step_coeff;
  logic             out_load;
  lmb_log_req_t     log_req;
  lmb_log_rsp_t     log_rsp;

  function automatic logic [19:0] step_toward(logic [19:0] cur, logic [19:0] tgt,
                                              logic [15:0] coeff);
    logic [19:0] diff;
    logic [35:0] prod;
    if (tgt > cur) begin
      diff = tgt - cur;
      prod = {20'd0, coeff} * {16'd0, diff};
      step_toward = cur + prod[35:16];
    end else begin
      diff = cur - tgt;
      prod = {20'd0, coeff} * {16'd0, diff} + 36'd65535;
      step_toward = cur - prod[35:16];
    end
  endfunction

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q     <= ATTACK_RESET;
      release_q    <= RELEASE_RESET;
      decay_q      <= DECAY_RESET;
      floor_q      <= FLOOR_RESET;
      ceiling_q    <= CEILING_RESET;
      hold_ticks_q <= HOLD_RESET;
    end else if (psel && penable && pwrite) begin
      case (lmb_reg_e'(paddr[4:2]))
        REG_ATTACK:  attack_q     <= pwdata[15:0];
        REG_RELEASE: release_q    <= pwdata[15:0];
        REG_DECAY:   decay_q      <= pwdata[15:0];
        REG_FLOOR:   floor_q      <= pwdata[15:0];
        REG_CEILING: ceiling_q    <= pwdata[15:0];
        REG_HOLD:    hold_ticks_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (lmb_reg_e'(paddr[4:2]))
      REG_ATTACK:  prdata = {16'd0, attack_q};
      REG_RELEASE: prdata = {16'd0, release_q};
      REG_DECAY:   prdata = {16'd0, decay_q};
      REG_FLOOR:   prdata = {16'd0, floor_q};
      REG_CEILING: prdata = {16'd0, ceiling_q};
      REG_HOLD:    prdata = {24'd0, hold_ticks_q};
      default:     prdata = 32'd0;
    endcase
  end

  // Input side and channel RAM.
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign ch_ext     = {3'd0, in_data_i.channel_index};
  assign in_range   = (ch_ext < 5'(CHANNELS));

  assign wentry = '{level: lvl_q, peak: peak_q, peak_db: pdb_q, hold: hold_q};

  lmb_ram #(
    .WIDTH (EW),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == S_WRITE),
    .waddr_i (idx_q),
    .wdata_i (wentry),
    .re_i    (in_accept),
    .raddr_i (ch_ext[CH_AW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    if (valid_q[idx_q]) begin
      entry = lmb_entry_t'(rdata);
    end else begin
      entry = '{level: 20'd0, peak: 20'd0, peak_db: PEAK_DB_RESET, hold: 8'd0};
    end
  end

  // Shared smoothing step for the level and the peak decay.
  always_comb begin
    if (state_q == S_PK_STEP) begin
      step_cur   = peak_q;
      step_tgt   = lvl_q;
      step_coeff = decay_q;
    end else begin
      step_cur   = entry.level;
      step_tgt   = nl_q;
      step_coeff = (nl_q > entry.level) ? attack_q : release_q;
    end
    step_res = step_toward(step_cur, step_tgt, step_coeff);
  end

  assign log_req.start = (state_q == S_LVL_START) || (state_q == S_PK_START);
  assign log_req.x     = (state_q == S_PK_START) ? peak_q : lvl_q;

  lmb_log_db u_log (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (log_req),
    .floor_db_i   (floor_q),
    .ceiling_db_i (ceiling_q),
    .rsp_o        (log_rsp)
  );

  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      ch_q        <= '0;
      nl_q        <= '0;
      lvl_q       <= '0;
      peak_q      <= '0;
      ldb_q       <= '0;
      pdb_q       <= '0;
      hold_q      <= '0;
      out_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_q       <= '{out_channel: ch_q, smoothed_level: lvl_q,
                         level_db_out: ldb_q, peak_db_out: pdb_q};
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            ch_q  <= in_data_i.channel_index;
            nl_q  <= in_data_i.new_level;
            idx_q <= ch_ext[CH_AW-1:0];
            if (in_range) begin
              state_q <= S_STEP;
            end else begin
              lvl_q   <= '0;
              ldb_q   <= floor_q;
              pdb_q   <= floor_q;
              state_q <= S_OUT;
            end
          end
        end
        S_STEP: begin
          lvl_q   <= step_res;
          peak_q  <= entry.peak;
          pdb_q   <= entry.peak_db;
          hold_q  <= entry.hold;
          state_q <= S_LVL_START;
        end
        S_LVL_START: state_q <= S_LVL_WAIT;
        S_LVL_WAIT: begin
          if (log_rsp.done) begin
            ldb_q <= log_rsp.db;
            if (lvl_q > peak_q) begin
              peak_q  <= lvl_q;
              pdb_q   <= log_rsp.db;
              hold_q  <= hold_ticks_q;
              state_q <= S_WRITE;
            end else if (hold_q != 8'd0) begin
              hold_q  <= hold_q - 8'd1;
              state_q <= S_WRITE;
            end else if ($signed(pdb_q) > $signed(floor_q)) begin
              state_q <= S_PK_STEP;
            end else begin
              state_q <= S_WRITE;
            end
          end
        end
        S_PK_STEP: begin
          peak_q  <= step_res;
          state_q <= S_PK_START;
        end
        S_PK_START: state_q <= S_PK_WAIT;
        S_PK_WAIT: begin
          if (log_rsp.done) begin
            pdb_q   <= log_rsp.db;
            state_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          valid_q[idx_q] <= 1'b1;
          state_q        <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
